@@ rtl/bfa_pkg.sv @@
// bfa_pkg: shared types and constants for the bitmap frame allocator
// request and result payloads, configuration register indexes, status codes
// and the command/status bundles between controller and datapath; no dependencies
package bfa_pkg;

	localparam int ADDR_W    = 64;
	localparam int FC_W      = 13;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd2;

	// request function codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   alloc_addr;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clr;     // clearing pass, one word per cycle
		logic load;    // take the request transfer
		logic grp;     // pick lowest group with a non-full word
		logic wrd;     // pick word inside group, read it
		logic eval;    // find lowest free frame in read word
		logic fchk;    // free: range and alignment checks
		logic fidx;    // free: frame index, read word
		logic commit;  // write back, load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic in_func;
	} sts_t;

endpackage

@@ rtl/bfa_ctrl.sv @@
// bfa_ctrl: request sequencer of the bitmap frame allocator
// drives bfa_dpath through bfa_pkg::cmd_t and owns the result valid flag
// depends on bfa_pkg
module bfa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bfa_pkg::sts_t sts,
	output bfa_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_A_GRP,
		S_A_WRD,
		S_A_RD,
		S_F_CHK,
		S_F_IDX,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr    = 1'b1;
			S_IDLE:  cmd.load   = in_valid;
			S_A_GRP: cmd.grp    = 1'b1;
			S_A_WRD: cmd.wrd    = 1'b1;
			S_A_RD:  cmd.eval   = 1'b1;
			S_F_CHK: cmd.fchk   = 1'b1;
			S_F_IDX: cmd.fidx   = 1'b1;
			S_DONE:  cmd.commit = !out_valid_q || out_ready;
			default: cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (sts.in_func == bfa_pkg::FUNC_FREE) ? S_F_CHK : S_A_GRP;
					end
				end
				S_A_GRP: state_q <= S_A_WRD;
				S_A_WRD: state_q <= S_A_RD;
				S_A_RD:  state_q <= S_DONE;
				S_F_CHK: state_q <= S_F_IDX;
				S_F_IDX: state_q <= S_DONE;
				S_DONE:  if (cmd.commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/bfa_dpath.sv @@
// bfa_dpath: datapath of the bitmap frame allocator
// configuration registers, bitmap memory, per-word full flags, search and address logic
// depends on bfa_pkg; sequenced by bfa_ctrl
module bfa_dpath #(
	parameter int FRAME_SLOTS = 4096,
	parameter int PAGE_BYTES  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bfa_pkg::ADDR_W-1:0]       cfg_wdata,
	input  bfa_pkg::req_t                    in_data,
	input  bfa_pkg::cmd_t                    cmd,
	output bfa_pkg::sts_t                    sts,
	output bfa_pkg::rsp_t                    out_data
);

	localparam int MAP_WORDS = (FRAME_SLOTS + 63) / 64;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int NGRP      = (MAP_WORDS + 31) / 32;
	localparam int GW        = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int NG        = 2 ** GW;
	localparam int WX_W      = GW + 5;
	localparam int NPAD      = NG * 32;
	localparam int CW        = $clog2(FRAME_SLOTS + 1);
	localparam int HI_W      = CW - 6;
	localparam int SHIFT     = $clog2(PAGE_BYTES);
	localparam logic [NPAD-1:0] FULL_RST = {NPAD{1'b1}} << MAP_WORDS;

	function automatic logic [5:0] lowest_one(input logic [63:0] v);
		logic [2:0] by;
		logic [2:0] bi;
		logic [7:0] sel;
		by = '0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i*8 +: 8] != 8'h00) by = 3'(i);
		end
		sel = v[by*8 +: 8];
		bi  = '0;
		for (int i = 7; i >= 0; i--) begin
			if (sel[i]) bi = 3'(i);
		end
		return {by, bi};
	endfunction

	// configuration
	logic [bfa_pkg::ADDR_W-1:0] rstart_q;
	logic [bfa_pkg::ADDR_W-1:0] rend_q;
	logic [bfa_pkg::FC_W-1:0]   fcount_q;

	// bitmap store and flags
	logic [63:0]     mem [MAP_WORDS];
	logic [63:0]     rd_q;
	logic [NPAD-1:0] full_q;
	logic [AW-1:0]   clr_cnt_q;

	// per-request state
	bfa_pkg::req_t              req_q;
	logic [CW-1:0]              cnt_q;
	logic [GW-1:0]              grp_q;
	logic                       any_q;
	logic [WX_W-1:0]            widx_q;
	logic [5:0]                 bit_q;
	logic                       found_q;
	logic                       bad_q;
	logic [bfa_pkg::ADDR_W-1:0] diff_q;
	bfa_pkg::rsp_t              out_q;

	logic [CW-1:0]     eff_cnt;
	logic [NG-1:0]     grp_full;
	logic [GW-1:0]     grp_sel;
	logic              grp_any;
	logic [31:0]       sub_flags;
	logic [4:0]        sub_sel;
	logic [WX_W-1:0]   word_sel;
	logic [CW-1:0]     idx_c;
	logic              free_ok;
	logic [HI_W-1:0]   hi_cnt;
	logic [63:0]       vmask;
	logic [63:0]       free_bits;
	logic [63:0]       onehot;
	logic [63:0]       new_word;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [bfa_pkg::ADDR_W-1:0] frame_addr;

	assign eff_cnt = (32'(fcount_q) > 32'(FRAME_SLOTS)) ? CW'(FRAME_SLOTS) : CW'(fcount_q);

	// lowest group holding a word that is not full
	always_comb begin
		grp_sel = '0;
		grp_any = 1'b0;
		for (int g = 0; g < NG; g++) begin
			grp_full[g] = &full_q[g*32 +: 32];
		end
		for (int g = NG - 1; g >= 0; g--) begin
			if (!grp_full[g]) begin
				grp_sel = GW'(g);
				grp_any = 1'b1;
			end
		end
	end

	// lowest non-full word inside the chosen group
	always_comb begin
		sub_flags = full_q[grp_q*32 +: 32];
		sub_sel   = '0;
		for (int s = 31; s >= 0; s--) begin
			if (!sub_flags[s]) sub_sel = 5'(s);
		end
	end

	assign word_sel = {grp_q, sub_sel};

	// free: frame index and bound check
	assign idx_c   = diff_q[SHIFT+CW-1:SHIFT];
	assign free_ok = !bad_q && ((diff_q >> (SHIFT + CW)) == '0) && (idx_c < cnt_q);

	// allocate: bits of the read word below the frame count
	assign hi_cnt = cnt_q[CW-1:6];
	always_comb begin
		if (32'(widx_q) < 32'(hi_cnt)) begin
			vmask = '1;
		end else if (32'(widx_q) == 32'(hi_cnt)) begin
			vmask = (64'(1) << cnt_q[5:0]) - 64'(1);
		end else begin
			vmask = '0;
		end
	end
	assign free_bits = ~rd_q & vmask;

	assign onehot   = 64'(1) << bit_q;
	assign new_word = (req_q.func == bfa_pkg::FUNC_FREE) ? (rd_q & ~onehot) : (rd_q | onehot);
	assign frame_addr = rstart_q + (64'({widx_q, bit_q}) << SHIFT);

	assign rd_en   = cmd.wrd || cmd.fidx;
	assign rd_addr = cmd.fidx ? AW'(idx_c >> 6) : word_sel[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rstart_q  <= '0;
			rend_q    <= '0;
			fcount_q  <= '0;
			full_q    <= FULL_RST;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bfa_pkg::CFG_REGION_START: rstart_q <= cfg_wdata;
					bfa_pkg::CFG_REGION_END:   rend_q   <= cfg_wdata;
					bfa_pkg::CFG_FRAME_COUNT:  fcount_q <= cfg_wdata[bfa_pkg::FC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.commit && found_q) begin
				full_q[widx_q] <= (req_q.func == bfa_pkg::FUNC_FREE) ? 1'b0 : &new_word;
			end
		end
	end

	// bitmap memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.commit && found_q) begin
			mem[widx_q[AW-1:0]] <= new_word;
		end
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
			cnt_q <= eff_cnt;
		end
		if (cmd.grp) begin
			grp_q <= grp_sel;
			any_q <= grp_any;
		end
		if (cmd.wrd) widx_q <= word_sel;
		if (cmd.eval) begin
			bit_q   <= lowest_one(free_bits);
			found_q <= any_q && (free_bits != '0);
		end
		if (cmd.fchk) begin
			bad_q  <= (req_q.free_addr < rstart_q) || (req_q.free_addr >= rend_q) ||
			          (req_q.free_addr[SHIFT-1:0] != '0);
			diff_q <= req_q.free_addr - rstart_q;
		end
		if (cmd.fidx) begin
			widx_q  <= WX_W'(idx_c >> 6);
			bit_q   <= idx_c[5:0];
			found_q <= free_ok;
		end
		if (cmd.commit) begin
			if (req_q.func == bfa_pkg::FUNC_FREE) begin
				out_q.alloc_addr <= '0;
				out_q.status     <= found_q ? bfa_pkg::ST_FREED : bfa_pkg::ST_IGNORED;
			end else begin
				out_q.alloc_addr <= found_q ? frame_addr : '0;
				out_q.status     <= found_q ? bfa_pkg::ST_ALLOCATED : bfa_pkg::ST_NO_MEMORY;
			end
		end
	end

	assign sts.clr_done = (clr_cnt_q == AW'(MAP_WORDS - 1));
	assign sts.in_func  = in_data.func;
	assign out_data     = out_q;

endmodule

@@ rtl/bitmap_frame_allocator.sv @@
// bitmap_frame_allocator: first-fit page frame allocator over a used/free bitmap
// allocate: group search, word pick with bitmap read, lowest free bit, then write-back
// free: range and alignment checks, frame index with bitmap read, then write-back
// one request at a time: write-back waits while a result is held, then in_ready rises
// reset: clearing pass over every bitmap word before in_ready rises
// depends on bfa_pkg, bfa_ctrl, bfa_dpath
module bitmap_frame_allocator #(
	parameter int FRAME_SLOTS = 4096,  // frames the bitmap can hold, 64 to 65536
	parameter int PAGE_BYTES  = 4096   // page size, a power of two
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfa_pkg::ADDR_W-1:0]    cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bfa_pkg::req_t                 in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output bfa_pkg::rsp_t                 out_data
);

	// controller and datapath talk only through these two bundles
	bfa_pkg::cmd_t cmd;
	bfa_pkg::sts_t sts;

	// sequencer: clearing pass, then one request at a time; the result register
	// frees the request side as soon as a transfer's result is loaded
	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: bitmap memory of 64-bit words with a full flag per word;
	// allocation looks for the lowest group of 32 words that has a non-full one,
	// then the word, then the lowest free bit below the frame count
	bfa_dpath #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.PAGE_BYTES  (PAGE_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ tb/bitmap_frame_allocator_tb.sv @@
// bitmap_frame_allocator_tb: self-checking bench for the first-fit frame allocator,
// directed corner requests then randomised phases under random and long back-pressure
// depends on bfa_pkg and bitmap_frame_allocator only
`timescale 1ns / 100ps

module bitmap_frame_allocator_tb;

	localparam int        FRAMES    = 4096;        // bitmap size of the instance
	localparam bit [63:0] PAGE      = 64'd4096;    // page size of the instance
	localparam int        TAIL      = 12;          // quiet cycles after the last result
	localparam int        LIMIT     = 600000;      // watchdog, cycles
	localparam bit [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bfa_pkg::ADDR_W-1:0]    cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	bfa_pkg::req_t                 in_data;
	logic                          out_valid;
	logic                          out_ready;
	bfa_pkg::rsp_t                 out_data;

	// idle bursts on both sides while set; cleared for calm stretches and the closing run
	bit idle_on;
	// long receiver hold-off request, in cycles, picked up by the receiver process
	int hold_cycles;
	int unsigned cycles;

	// ------------------------------------------------------------------
	// allocator shadow and result queue
	// ------------------------------------------------------------------
	class frame_scoreboard;
		bit [63:0]     region_start;
		bit [63:0]     region_end;
		bit [12:0]     frame_count;
		bit            frame_used [FRAMES];
		bfa_pkg::rsp_t pending_rsp [$];
		int            errors;

		function new();
			region_start = '0;
			region_end   = '0;
			frame_count  = '0;
			foreach (frame_used[i]) frame_used[i] = 1'b0;
			errors = 0;
		endfunction

		// frames that may be handed out: the count saturates at the bitmap size
		function int live_frames();
			return (frame_count > FRAMES) ? FRAMES : int'(frame_count);
		endfunction

		function void write_reg(logic [bfa_pkg::CFG_IDX_W-1:0] idx, bit [63:0] value);
			case (idx)
				bfa_pkg::CFG_REGION_START: region_start = value;
				bfa_pkg::CFG_REGION_END:   region_end   = value;
				bfa_pkg::CFG_FRAME_COUNT:  frame_count  = value[12:0];
				default: ;
			endcase
		endfunction

		// work out the answer to one accepted request and queue it
		function void note_request(bfa_pkg::req_t r);
			bfa_pkg::rsp_t e;
			int            lim;
			int            i;
			bit [63:0]     idx;
			lim          = live_frames();
			e.alloc_addr = '0;
			if (r.func == bfa_pkg::FUNC_ALLOC) begin
				e.status = bfa_pkg::ST_NO_MEMORY;
				for (i = 0; i < lim; i++) begin
					if (!frame_used[i]) begin
						frame_used[i] = 1'b1;
						// wraps modulo 2^64 by width
						e.alloc_addr  = region_start + 64'(i) * PAGE;
						e.status      = bfa_pkg::ST_ALLOCATED;
						break;
					end
				end
			end else begin
				e.status = bfa_pkg::ST_IGNORED;
				if (r.free_addr >= region_start && r.free_addr < region_end &&
				    (r.free_addr % PAGE) == 0) begin
					idx = (r.free_addr - region_start) / PAGE;
					// stored bits past the count are left alone
					if (idx < 64'(lim)) begin
						frame_used[idx] = 1'b0;
						e.status        = bfa_pkg::ST_FREED;
					end
				end
			end
			pending_rsp.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		function int outstanding();
			return pending_rsp.size();
		endfunction

		task check_result(bfa_pkg::rsp_t got);
			bfa_pkg::rsp_t e;
			if (pending_rsp.size() == 0) begin
				report($sformatf("result with nothing outstanding: addr %h status %0d",
					got.alloc_addr, got.status));
				return;
			end
			e = pending_rsp.pop_front();
			if (got.alloc_addr !== e.alloc_addr)
				report($sformatf("alloc_addr %h, predicted %h", got.alloc_addr, e.alloc_addr));
			if (got.status !== e.status)
				report($sformatf("status %0d, predicted %0d", got.status, e.status));
		endtask
	endclass

	frame_scoreboard sb = new();

	bitmap_frame_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("bitmap_frame_allocator verification failed");
			$finish;
		end
	end

	// result monitor, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// receiver side: random stall bursts, long hold-off on request, otherwise ready
	initial begin : rx_side
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				n           = hold_cycles;
				hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one request transfer; a random gap, while idle bursts are on, keeps valid low first
	task automatic send_req(input logic func, input bit [63:0] addr);
		bfa_pkg::req_t r;
		int            gap;
		r.func      = func;
		r.free_addr = addr;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic alloc_req();
		// address field is don't-care on allocate, fill it with noise
		send_req(bfa_pkg::FUNC_ALLOC, {$urandom, $urandom});
	endtask

	// sender pauses until every predicted result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	// register writes, only with the block idle
	task automatic program_regs(bit [63:0] start, bit [63:0] limit_addr, bit [63:0] count);
		bit [63:0]                     vals [3];
		logic [bfa_pkg::CFG_IDX_W-1:0] idxs [3];
		int k;
		vals[0] = start;      idxs[0] = bfa_pkg::CFG_REGION_START;
		vals[1] = limit_addr; idxs[1] = bfa_pkg::CFG_REGION_END;
		vals[2] = count;      idxs[2] = bfa_pkg::CFG_FRAME_COUNT;
		for (k = 0; k < 3; k++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idxs[k];
			cfg_wdata <= vals[k];
			@(posedge clk);
			sb.write_reg(idxs[k], vals[k]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one randomised request against the current register settings
	task automatic random_req();
		int        pick;
		int        lim;
		int        span;
		bit [63:0] idx;
		lim  = sb.live_frames();
		span = (lim > 256) ? 256 : lim;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			alloc_req();
		end else if (pick < 90) begin
			// well-formed free, now and then just past the count
			if (lim > 256 && $urandom_range(0, 7) == 0)
				idx = $urandom_range(0, lim + 2);
			else
				idx = $urandom_range(0, span + 2);
			send_req(bfa_pkg::FUNC_FREE, sb.region_start + idx * PAGE);
		end else begin
			idx = $urandom_range(0, span + 2);
			case ($urandom_range(0, 3))
				0: send_req(bfa_pkg::FUNC_FREE, {$urandom, $urandom});
				1: send_req(bfa_pkg::FUNC_FREE, sb.region_start + idx * PAGE +
					64'($urandom_range(1, int'(PAGE) - 1)));
				2: send_req(bfa_pkg::FUNC_FREE,
					sb.region_start - 64'($urandom_range(1, 4)) * PAGE);
				default: send_req(bfa_pkg::FUNC_FREE, sb.region_end);
			endcase
		end
	endtask

	// new random settings, then a batch of requests
	task automatic random_phase(int n_items, bit hold_off);
		bit [63:0] start;
		bit [63:0] limit_addr;
		bit [63:0] count;
		int        i;
		case ($urandom_range(0, 9))
			0:       count = 0;
			1:       count = 1;
			2:       count = 64;
			3:       count = 65;
			4:       count = FRAMES;
			5:       count = 13'h1FFF;
			6:       count = $urandom_range(2, 8191);
			default: count = $urandom_range(2, 200);
		endcase
		case ($urandom_range(0, 5))
			0:       start = '0;
			1:       start = ALL_ONES - 64'($urandom_range(1, 8)) * PAGE + 1;
			default: start = {$urandom, $urandom} & ~(PAGE - 1);
		endcase
		case ($urandom_range(0, 5))
			0:       limit_addr = ALL_ONES;
			1:       limit_addr = {$urandom, $urandom};
			default: limit_addr = start +
				(((count > FRAMES) ? 64'(FRAMES) : count) + 64'($urandom_range(0, 16))) * PAGE;
		endcase
		program_regs(start, limit_addr, count);
		if (hold_off)
			hold_cycles = 300;
		for (i = 0; i < n_items; i++)
			random_req();
		drain();
	endtask

	initial begin : main_seq
		bit [63:0] base;
		bit [63:0] top_page;
		int        ph;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = bfa_pkg::CFG_REGION_START;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		idle_on     = 1'b1;
		hold_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: 70 frames spanning two bitmap words, region larger than the count
		base = 64'h0000_0000_8000_0000;
		program_regs(base, base + 100 * PAGE, 70);
		send_req(bfa_pkg::FUNC_FREE, base);                 // frame already free
		alloc_req();                                        // frames 0, 1, 2
		alloc_req();
		alloc_req();
		send_req(bfa_pkg::FUNC_FREE, base + PAGE);          // release frame 1
		alloc_req();                                        // lowest free is 1 again
		alloc_req();                                        // frame 3
		send_req(bfa_pkg::FUNC_FREE, base + PAGE + 8);      // not page aligned
		send_req(bfa_pkg::FUNC_FREE, base - PAGE);          // below the region
		send_req(bfa_pkg::FUNC_FREE, base + 100 * PAGE);    // at the exclusive end
		send_req(bfa_pkg::FUNC_FREE, base + 80 * PAGE);     // inside region, past the count
		send_req(bfa_pkg::FUNC_FREE, '0);
		send_req(bfa_pkg::FUNC_FREE, ALL_ONES);
		drain();

		// shrink the count: frames 2 and 3 hidden, 0 and 1 used, so nothing to give
		program_regs(base, base + 100 * PAGE, 2);
		alloc_req();
		send_req(bfa_pkg::FUNC_FREE, base + 3 * PAGE);      // past the count, stored bit kept
		drain();
		program_regs(base, base + 100 * PAGE, 0);
		alloc_req();                                        // empty allocator
		send_req(bfa_pkg::FUNC_FREE, base);
		drain();
		// raise it again: frame 3 still shows as used, next is frame 4
		program_regs(base, base + 100 * PAGE, 70);
		alloc_req();
		drain();

		// saturated count and an address range that wraps past the top
		top_page = ALL_ONES - 2 * PAGE + 1;
		program_regs(top_page, ALL_ONES, 13'h1FFF);
		send_req(bfa_pkg::FUNC_FREE, top_page);             // frame 0
		send_req(bfa_pkg::FUNC_FREE, top_page + PAGE);      // frame 1, last page below the top
		alloc_req();
		alloc_req();
		alloc_req();                                        // frame 5, wraps to the bottom
		drain();

		// empty region at address zero: every free is outside
		program_regs('0, '0, FRAMES);
		send_req(bfa_pkg::FUNC_FREE, '0);
		alloc_req();
		drain();

		// randomised phases; one of them starves the result side for a long stretch
		for (ph = 0; ph < 8; ph++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			random_phase(150, ph == 2);
		end

		// closing run with both sides always ready
		idle_on = 1'b0;
		random_phase(200, 1'b0);

		if (sb.errors == 0)
			$display("bitmap_frame_allocator verification clean");
		else
			$display("bitmap_frame_allocator verification failed");
		$finish;
	end

endmodule
